// File: design/jkcm_pkg.sv
package jkcm_pkg;

  // Sequencer states of the key count table.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_PRODUCT,
    ST_EMIT
  } state_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  // Item modes.
  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  // One table slot as stored in memory.
  typedef struct packed {
    logic        used;
    logic [31:0] count;
    logic [63:0] key;
  } slot_t;

  localparam logic [31:0] HASH_MULT  = 32'h9E37_79B1;
  localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;
  localparam logic [63:0] ONE_Q16    = 64'h0000_0000_0001_0000;
  localparam logic [63:0] ZERO_Q16   = 64'h0;

endpackage

// File: design/join_key_count_multiplier.sv
// Join key count table. A build item (tuser mode 0) counts a non-null 64-bit key in an
// open-addressed table of TABLE_SLOTS slots with linear probing; a probe item (mode 1)
// returns the stored count times the inverse_rate register (Q16.16) as a Q48.16
// multiplier, and the same value or 1.0 where it is zero. Every item gives one result.
// After reset the block sweeps the table clear, one slot per cycle, before it takes
// the first item; configuration writes are taken at any time. A non-null item
// inspects 1 up to TABLE_SLOTS slots, and no new item is taken before its result is
// loaded into the output register: the single read port of the slot memory walks
// the probe chain one slot per cycle, and the hash uses a shared 32x32 multiplier for
// its low and high halves plus, when TABLE_SLOTS is not a power of two, an eight-step
// reduction modulo the table size. A null key skips the hash and the chain. A result
// waiting in the output register does not block the next item from being accepted.
module join_key_count_multiplier #(
  parameter int TABLE_SLOTS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Input item.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,   // [63:0] key
  input  logic [1:0]    s_axis_tuser,   // [0] mode, [1] key_is_null
  // Result item.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [159:0]  m_axis_tdata,   // [63:0] multiplier, [127:64] multiplier_nonzero,
                                        // [159:128] match_count
  output logic [1:0]    m_axis_tuser,   // [1:0] status
  // Configuration write of inverse_rate.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [31:0]   cfg_data_i
);

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W = $bits(jkcm_pkg::slot_t);
  localparam int REM_W   = IDX_W + 8;
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [REM_W-1:0] SLOTS_WIDE = REM_W'(TABLE_SLOTS);
  localparam logic [2:0]       LAST_DIGIT = 3'd7;

  jkcm_pkg::state_e  state_q, state_d;
  logic              out_valid_q;
  logic [31:0]       inverse_rate_q;
  logic [IDX_W-1:0]  clr_q;

  // Item payload and working registers.
  logic              mode_q;
  logic [63:0]       key_q;
  logic [63:0]       h1_q;
  logic [63:0]       prod_q;
  logic [31:0]       prod_hi_q;
  logic [63:0]       mod_shift_q;
  logic [IDX_W-1:0]  rem_q;
  logic [2:0]        digit_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  probes_q;
  logic [31:0]       count_q;
  jkcm_pkg::status_e status_q;
  logic [159:0]      out_data_q;
  logic [1:0]        out_user_q;

  // Memory ports.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  jkcm_pkg::slot_t     ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  jkcm_pkg::slot_t     slot;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic              in_fire, out_load;
  logic [63:0]       h1_in, h2, h3;
  logic [REM_W-1:0]  rem_work;
  logic [IDX_W-1:0]  next_idx;
  logic              slot_hit, slot_empty, last_probe, keep_probing;
  logic              is_build, count_at_max;
  logic [31:0]       check_count;
  jkcm_pkg::status_e check_status;
  logic [63:0]       mu, mu_nn;

  jkcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot  = jkcm_pkg::slot_t'(ram_rdata);
  assign mul_p = mul_a * mul_b;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == jkcm_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign is_build = (mode_q == jkcm_pkg::MODE_BUILD);

  // Key folding ahead of the hash multiply.
  always_comb begin
    h1_in = s_axis_tdata ^ (s_axis_tdata >> 32);
    h1_in = h1_in ^ (h1_in >> 16);
  end

  // Hash product recombined from the two partial products, then mixed.
  assign h2 = prod_q + {prod_hi_q, 32'h0};
  assign h3 = h2 ^ (h2 >> 29);

  // One byte of the modulo reduction: restoring steps against shifted table sizes.
  always_comb begin
    rem_work = {rem_q, mod_shift_q[63:56]};
    for (int j = 7; j >= 0; j--) begin
      if (rem_work >= (SLOTS_WIDE << j)) begin
        rem_work = rem_work - (SLOTS_WIDE << j);
      end
    end
  end

  assign next_idx = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

  // Slot inspection for the probe chain.
  assign slot_empty   = !slot.used;
  assign slot_hit     = slot.used && (slot.key == key_q);
  assign last_probe   = (probes_q == LAST_IDX);
  assign keep_probing = slot.used && !slot_hit && !last_probe;
  assign count_at_max = (slot.count == jkcm_pkg::COUNT_MAX);

  always_comb begin
    check_count  = 32'h0;
    check_status = jkcm_pkg::STATUS_OK;
    if (slot_empty) begin
      check_count = is_build ? 32'd1 : 32'h0;
    end else if (slot_hit) begin
      if (is_build && !count_at_max) begin
        check_count = slot.count + 32'd1;
      end else begin
        check_count = slot.count;
      end
      if (is_build && count_at_max) begin
        check_status = jkcm_pkg::STATUS_SAT;
      end
    end else if (is_build) begin
      check_status = jkcm_pkg::STATUS_FULL;
    end
  end

  // Result formatting.
  assign mu    = is_build ? jkcm_pkg::ZERO_Q16 : prod_q;
  assign mu_nn = is_build ? jkcm_pkg::ZERO_Q16 :
                 ((prod_q == 64'h0) ? jkcm_pkg::ONE_Q16 : prod_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      jkcm_pkg::ST_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = jkcm_pkg::ST_IDLE;
      end
      jkcm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = s_axis_tuser[1] ? jkcm_pkg::ST_PRODUCT : jkcm_pkg::ST_MUL_LO;
        end
      end
      jkcm_pkg::ST_MUL_LO:   state_d = jkcm_pkg::ST_MUL_HI;
      jkcm_pkg::ST_MUL_HI:   state_d = jkcm_pkg::ST_HASH;
      jkcm_pkg::ST_HASH: begin
        state_d = IS_POW2 ? jkcm_pkg::ST_READ : jkcm_pkg::ST_MOD;
      end
      jkcm_pkg::ST_MOD: begin
        if (digit_q == LAST_DIGIT) state_d = jkcm_pkg::ST_READ;
      end
      jkcm_pkg::ST_READ:     state_d = jkcm_pkg::ST_CHECK;
      jkcm_pkg::ST_CHECK: begin
        if (!keep_probing) state_d = jkcm_pkg::ST_PRODUCT;
      end
      jkcm_pkg::ST_PRODUCT:  state_d = jkcm_pkg::ST_EMIT;
      jkcm_pkg::ST_EMIT: begin
        if (out_load) state_d = jkcm_pkg::ST_IDLE;
      end
      default:               state_d = jkcm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory ports and multiplier operands.
  always_comb begin
    s_axis_tready = (state_q == jkcm_pkg::ST_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;
    ram_raddr     = idx_q;
    mul_a         = h1_q[31:0];
    mul_b         = jkcm_pkg::HASH_MULT;
    case (state_q)
      jkcm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
      end
      jkcm_pkg::ST_MUL_HI: begin
        mul_a = h1_q[63:32];
      end
      jkcm_pkg::ST_CHECK: begin
        ram_raddr       = next_idx;
        ram_wdata.used  = 1'b1;
        ram_wdata.count = check_count;
        ram_wdata.key   = key_q;
        ram_we          = is_build && (slot_empty || (slot_hit && !count_at_max));
      end
      jkcm_pkg::ST_PRODUCT: begin
        mul_a = count_q;
        mul_b = inverse_rate_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= jkcm_pkg::ST_CLEAR;
      clr_q          <= '0;
      out_valid_q    <= 1'b0;
      inverse_rate_q <= 32'h0001_0000;
    end else begin
      state_q <= state_d;
      if (state_q == jkcm_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        inverse_rate_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      jkcm_pkg::ST_IDLE: begin
        mode_q   <= s_axis_tuser[0];
        key_q    <= s_axis_tdata;
        h1_q     <= h1_in;
        count_q  <= 32'h0;
        status_q <= jkcm_pkg::STATUS_OK;
      end
      jkcm_pkg::ST_MUL_LO: begin
        prod_q <= mul_p;
      end
      jkcm_pkg::ST_MUL_HI: begin
        prod_hi_q <= mul_p[31:0];
      end
      jkcm_pkg::ST_HASH: begin
        mod_shift_q <= h3;
        rem_q       <= '0;
        digit_q     <= '0;
        idx_q       <= h3[IDX_W-1:0];
        probes_q    <= '0;
      end
      jkcm_pkg::ST_MOD: begin
        rem_q       <= rem_work[IDX_W-1:0];
        mod_shift_q <= mod_shift_q << 8;
        digit_q     <= digit_q + 1'b1;
        idx_q       <= rem_work[IDX_W-1:0];
      end
      jkcm_pkg::ST_CHECK: begin
        if (keep_probing) begin
          idx_q    <= next_idx;
          probes_q <= probes_q + 1'b1;
        end
        count_q  <= check_count;
        status_q <= check_status;
      end
      jkcm_pkg::ST_PRODUCT: begin
        prod_q <= mul_p;
      end
      jkcm_pkg::ST_EMIT: begin
        if (out_load) begin
          out_data_q <= {count_q, mu_nn, mu};
          out_user_q <= status_q;
        end
      end
      default: begin
        prod_hi_q <= prod_hi_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// File: design/jkcm_ram.sv
module jkcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
